[rtl/core/linear_scan_register_assign_unit_assert.svh]
// assertion macros for the linear scan register assign unit
`ifndef LINEAR_SCAN_REGISTER_ASSIGN_UNIT_ASSERT_SVH
`define LINEAR_SCAN_REGISTER_ASSIGN_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define LSRA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define LSRA_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LSRA_ASSERT(name, clk, rst_n, prop, msg)
`define LSRA_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

[rtl/core/lsra_pkg.sv]
// shared types and constants for the linear scan register assign unit
package lsra_pkg;

  // field widths of the input transaction
  localparam int unsigned TEMP_ID_W  = 16;
  localparam int unsigned POS_W      = 20;
  localparam int unsigned WCOUNT_W   = 32;
  localparam int unsigned ACOUNT_W   = 16;
  localparam int unsigned BCOUNT_W   = 12;

  // field widths of the output transaction
  localparam int unsigned REG_NUM_W  = 5;
  localparam int unsigned SPILL_W    = 16;
  localparam int unsigned MASK_W     = 10;

  // stream widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 56;

  // input bit offsets
  localparam int unsigned IN_NEWF_LSB  = 0;
  localparam int unsigned IN_ID_LSB    = 1;
  localparam int unsigned IN_START_LSB = 17;
  localparam int unsigned IN_END_LSB   = 37;
  localparam int unsigned IN_WCNT_LSB  = 57;
  localparam int unsigned IN_ACNT_LSB  = 89;
  localparam int unsigned IN_BCNT_LSB  = 105;
  localparam int unsigned IN_PARAM_LSB = 117;
  localparam int unsigned IN_CROSS_LSB = 118;
  localparam int unsigned IN_USED_W    = 119;

  // output packed width before padding
  localparam int unsigned OUT_USED_W = 49;

  // internal widths
  localparam int unsigned STAMP_W = 16;
  localparam int unsigned PRIO_W  = 36;

  // register numbering
  localparam int unsigned CALLER_REG   = 8;
  localparam int unsigned FIRST_CALLEE = 19;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic expire;
    logic select;
    logic scan;
    logic commit;
  } lsra_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic free_found;
    logic scan_last;
  } lsra_sts_t;

endpackage

[rtl/core/linear_scan_register_assign_unit.sv]
// top level of the linear scan register assign unit
//
//   channel   direction  width  carries
//   s_axis    in         120    one live interval per transaction
//   m_axis    out        56     one assignment result per transaction
//
// an interval with a free register passes accept, expire, select and commit;
// with every legal slot busy the victim scan runs between select and commit,
// visiting CALLEE_REGS or CALLEE_REGS + 1 slots with the single shared
// victim comparator
// a new interval is taken once the previous one has committed; the result
// register holds while m_axis stalls, and commit waits only if it is still full
// reset clears slot occupancy, counters and the used mask; no clearing pass
module linear_scan_register_assign_unit import lsra_pkg::*; #(
  parameter int unsigned CALLEE_REGS = 10,
  parameter int unsigned POS_BITS    = 20,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // new_function, temp_id, start_pos, end_pos, weighted_count, access_count,
  // block_count, is_param, crosses_call, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // granted, reg_num, evicted, evicted_temp, spill_total, callee_used_mask,
  // zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  `include "linear_scan_register_assign_unit_assert.svh"

  lsra_cmd_t cmd;
  lsra_sts_t sts;

  logic                 granted;
  logic [REG_NUM_W-1:0] reg_num;
  logic                 evicted;
  logic [TEMP_ID_W-1:0] evicted_temp;
  logic [SPILL_W-1:0]   spill_total;
  logic [MASK_W-1:0]    used_mask;

  lsra_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // field slicing of the input transaction
  lsra_dpath #(
    .CALLEE_REGS (CALLEE_REGS),
    .POS_BITS    (POS_BITS),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .new_function_i     (s_axis_tdata[IN_NEWF_LSB]),
    .temp_id_i          (s_axis_tdata[IN_ID_LSB +: TEMP_ID_W]),
    .start_pos_i        (s_axis_tdata[IN_START_LSB +: POS_W]),
    .end_pos_i          (s_axis_tdata[IN_END_LSB +: POS_W]),
    .weighted_count_i   (s_axis_tdata[IN_WCNT_LSB +: WCOUNT_W]),
    .access_count_i     (s_axis_tdata[IN_ACNT_LSB +: ACOUNT_W]),
    .block_count_i      (s_axis_tdata[IN_BCNT_LSB +: BCOUNT_W]),
    .is_param_i         (s_axis_tdata[IN_PARAM_LSB]),
    .crosses_call_i     (s_axis_tdata[IN_CROSS_LSB]),
    .granted_o          (granted),
    .reg_num_o          (reg_num),
    .evicted_o          (evicted),
    .evicted_temp_o     (evicted_temp),
    .spill_total_o      (spill_total),
    .callee_used_mask_o (used_mask)
  );

  // pack result fields, lowest first, pad to bytes
  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, used_mask, spill_total,
                         evicted_temp, evicted, reg_num, granted};

  // an accepted interval keeps the input closed for at least the next cycle
  `LSRA_ASSERT(a_busy_after_accept, clk_i, rst_ni,
               (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input reopened too early")

  // an eviction always hands over a register
  `LSRA_ASSERT_NEVER(a_evict_without_grant, clk_i, rst_ni,
                     m_axis_tvalid && evicted && !granted, "eviction without grant")

  // a spilled interval reports register zero
  `LSRA_ASSERT_NEVER(a_spill_reg_zero, clk_i, rst_ni,
                     m_axis_tvalid && !granted && (reg_num != '0), "spill with register number")

  // a fresh result appears only as the controller returns to accept
  `LSRA_ASSERT(a_result_then_ready, clk_i, rst_ni,
               $rose(m_axis_tvalid) |-> s_axis_tready, "result without return to idle")

endmodule

[rtl/core/lsra_ctrl.sv]
// controller state machine of the linear scan register assign unit
module lsra_ctrl import lsra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  output lsra_cmd_t cmd_o,
  input  lsra_sts_t sts_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPIRE = 5'b00010,
    ST_SELECT = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_COMMIT = 5'b10000
  } lsra_state_e;

  lsra_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free  = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.expire = (state_q == ST_EXPIRE);
    cmd_o.select = (state_q == ST_SELECT);
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.commit = (state_q == ST_COMMIT) && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_valid_i) state_d = ST_EXPIRE;
      ST_EXPIRE: state_d = ST_SELECT;
      ST_SELECT: state_d = sts_i.free_found ? ST_COMMIT : ST_SCAN;
      ST_SCAN:   if (sts_i.scan_last) state_d = ST_COMMIT;
      ST_COMMIT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_ready_i;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/lsra_dpath.sv]
// slot file, free search, victim scan and result registers
module lsra_dpath import lsra_pkg::*; #(
  parameter int unsigned CALLEE_REGS = 10,
  parameter int unsigned POS_BITS    = 20,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsra_cmd_t            cmd_i,
  output lsra_sts_t            sts_o,
  input  logic                 new_function_i,
  input  logic [TEMP_ID_W-1:0] temp_id_i,
  input  logic [POS_W-1:0]     start_pos_i,
  input  logic [POS_W-1:0]     end_pos_i,
  input  logic [WCOUNT_W-1:0]  weighted_count_i,
  input  logic [ACOUNT_W-1:0]  access_count_i,
  input  logic [BCOUNT_W-1:0]  block_count_i,
  input  logic                 is_param_i,
  input  logic                 crosses_call_i,
  output logic                 granted_o,
  output logic [REG_NUM_W-1:0] reg_num_o,
  output logic                 evicted_o,
  output logic [TEMP_ID_W-1:0] evicted_temp_o,
  output logic [SPILL_W-1:0]   spill_total_o,
  output logic [MASK_W-1:0]    callee_used_mask_o
);

  localparam int unsigned NSLOT  = CALLEE_REGS + 1;
  localparam int unsigned SLOT_W = $clog2(NSLOT);

  // slot file
  logic [NSLOT-1:0]    busy_q;
  logic [POS_BITS-1:0] slot_end_q   [NSLOT];
  logic [PRIO_W-1:0]   slot_prio_q  [NSLOT];
  logic [ID_BITS-1:0]  slot_id_q    [NSLOT];
  logic [STAMP_W-1:0]  slot_stamp_q [NSLOT];

  logic [STAMP_W-1:0]     stamp_q;
  logic [SPILL_W-1:0]     spill_q, spill_d;
  logic [CALLEE_REGS-1:0] mask_q, mask_d;

  // current interval
  logic [ID_BITS-1:0]  id_q;
  logic [POS_BITS-1:0] start_q, end_q;
  logic [WCOUNT_W-1:0] wcnt_q;
  logic [ACOUNT_W-1:0] acnt_q;
  logic [BCOUNT_W-1:0] bcnt_q;
  logic                param_q, cross_q;
  logic [PRIO_W-1:0]   prio_q;

  // free slot and victim tracking
  logic              sel_found_q;
  logic [SLOT_W-1:0] sel_q;
  logic [SLOT_W-1:0] scan_idx_q;
  logic              vic_valid_q;
  logic [SLOT_W-1:0] vic_idx_q;
  logic [PRIO_W-1:0] vic_prio_q;
  logic [POS_BITS-1:0] vic_end_q;
  logic [STAMP_W-1:0]  vic_stamp_q;

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              better;
  logic              victim_ok, have_sel, do_evict;
  logic [SLOT_W-1:0] sel_fin;
  logic [CALLEE_REGS-1:0] sel_bit;
  logic [REG_NUM_W-1:0]   reg_num;

  // lowest free slot, x8 first when allowed
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = NSLOT - 1; s >= 1; s--) begin
      if (!busy_q[s]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(s);
      end
    end
    if (!cross_q && !busy_q[0]) begin
      free_found = 1'b1;
      free_idx   = '0;
    end
  end

  // one slot per cycle against the best victim so far
  always_comb begin
    better = !vic_valid_q ||
             (slot_prio_q[scan_idx_q] < vic_prio_q) ||
             ((slot_prio_q[scan_idx_q] == vic_prio_q) &&
              ((slot_end_q[scan_idx_q] > vic_end_q) ||
               ((slot_end_q[scan_idx_q] == vic_end_q) &&
                (slot_stamp_q[scan_idx_q] < vic_stamp_q))));
  end

  assign sts_o.free_found = free_found;
  assign sts_o.scan_last  = (scan_idx_q == SLOT_W'(NSLOT - 1));

  // final decision
  assign victim_ok = vic_valid_q && (vic_prio_q < prio_q);
  assign have_sel  = sel_found_q || victim_ok;
  assign do_evict  = !sel_found_q && victim_ok;
  assign sel_fin   = sel_found_q ? sel_q : vic_idx_q;

  always_comb begin
    for (int i = 0; i < CALLEE_REGS; i++) begin
      sel_bit[i] = have_sel && (sel_fin == SLOT_W'(i + 1));
    end
  end

  always_comb begin
    if (!have_sel) begin
      reg_num = '0;
    end else if (sel_fin == '0) begin
      reg_num = REG_NUM_W'(CALLER_REG);
    end else begin
      reg_num = REG_NUM_W'(FIRST_CALLEE - 1 + 32'(sel_fin));
    end
  end

  always_comb begin
    spill_d = spill_q;
    if ((do_evict || !have_sel) && (spill_q != '1)) spill_d = spill_q + 1'b1;
    mask_d = mask_q | sel_bit;
  end

  // control state of the slot file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      stamp_q <= '0;
      spill_q <= '0;
      mask_q  <= '0;
    end else if (cmd_i.load && new_function_i) begin
      busy_q  <= '0;
      stamp_q <= '0;
      spill_q <= '0;
      mask_q  <= '0;
    end else if (cmd_i.expire) begin
      for (int s = 0; s < NSLOT; s++) begin
        if (slot_end_q[s] < start_q) busy_q[s] <= 1'b0;
      end
    end else if (cmd_i.commit) begin
      spill_q <= spill_d;
      mask_q  <= mask_d;
      if (have_sel) begin
        busy_q[sel_fin] <= 1'b1;
        stamp_q         <= stamp_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q    <= ID_BITS'(temp_id_i);
      start_q <= POS_BITS'(start_pos_i);
      end_q   <= POS_BITS'(end_pos_i);
      wcnt_q  <= weighted_count_i;
      acnt_q  <= access_count_i;
      bcnt_q  <= block_count_i;
      param_q <= is_param_i;
      cross_q <= crosses_call_i;
    end
    if (cmd_i.expire) begin
      prio_q <= (PRIO_W'(wcnt_q) << 3) + (PRIO_W'(acnt_q) << 1) +
                (PRIO_W'(bcnt_q) << 4) + (PRIO_W'(param_q) << 3);
    end
    if (cmd_i.select) begin
      sel_found_q <= free_found;
      sel_q       <= free_idx;
      scan_idx_q  <= cross_q ? SLOT_W'(1) : '0;
      vic_valid_q <= 1'b0;
      vic_idx_q   <= '0;
    end
    if (cmd_i.scan) begin
      scan_idx_q <= scan_idx_q + 1'b1;
      if (busy_q[scan_idx_q] && better) begin
        vic_valid_q <= 1'b1;
        vic_idx_q   <= scan_idx_q;
        vic_prio_q  <= slot_prio_q[scan_idx_q];
        vic_end_q   <= slot_end_q[scan_idx_q];
        vic_stamp_q <= slot_stamp_q[scan_idx_q];
      end
    end
    if (cmd_i.commit) begin
      if (have_sel) begin
        slot_end_q[sel_fin]   <= end_q;
        slot_prio_q[sel_fin]  <= prio_q;
        slot_id_q[sel_fin]    <= id_q;
        slot_stamp_q[sel_fin] <= stamp_q;
      end
      granted_o          <= have_sel;
      reg_num_o          <= reg_num;
      evicted_o          <= do_evict;
      evicted_temp_o     <= do_evict ? TEMP_ID_W'(slot_id_q[vic_idx_q]) : '0;
      spill_total_o      <= spill_d;
      callee_used_mask_o <= MASK_W'(mask_d);
    end
  end

endmodule

[verif/tb.sv]
// self-checking testbench for the linear scan register assign unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsra_pkg::*;

  // one physical register per slot: x8, then the callee-saved x19 upwards
  localparam int NSLOT = 11;

  // result fields inside m_axis_tdata, lowest bit first
  localparam int OUT_GRANT_LSB = 0;
  localparam int OUT_REG_LSB   = 1;
  localparam int OUT_EV_LSB    = 6;
  localparam int OUT_EVID_LSB  = 7;
  localparam int OUT_SPILL_LSB = 23;
  localparam int OUT_MASK_LSB  = 39;

  // stimulus stops here; idling is switched off for the last stretch
  localparam int ITEM_TARGET = 1220;
  localparam int CALM_FROM   = 1020;
  // cycles with no transaction on either side before the run is abandoned
  localparam int IDLE_LIMIT  = 2000;

  // one live interval as presented on s_axis
  typedef struct {
    bit                 newf;
    bit [TEMP_ID_W-1:0] temp_id;
    bit [POS_W-1:0]     start_pos;
    bit [POS_W-1:0]     end_pos;
    bit [WCOUNT_W-1:0]  wcount;
    bit [ACOUNT_W-1:0]  acount;
    bit [BCOUNT_W-1:0]  bcount;
    bit                 is_param;
    bit                 crosses_call;
  } interval_t;

  // one assignment outcome as returned on m_axis
  typedef struct {
    bit                 granted;
    bit [REG_NUM_W-1:0] reg_num;
    bit                 evicted;
    bit [TEMP_ID_W-1:0] evicted_temp;
    bit [SPILL_W-1:0]   spill_total;
    bit [MASK_W-1:0]    used_mask;
  } grant_t;

  // register file occupancy model plus the queue of outcomes still to arrive
  class regalloc_book;
    bit                 busy       [NSLOT];
    bit [POS_W-1:0]     hold_end   [NSLOT];
    bit [PRIO_W-1:0]    hold_prio  [NSLOT];
    bit [TEMP_ID_W-1:0] hold_id    [NSLOT];
    bit [STAMP_W-1:0]   hold_stamp [NSLOT];
    bit [STAMP_W-1:0]   stamp;
    bit [SPILL_W-1:0]   spills;
    bit [MASK_W-1:0]    callee_mask;
    grant_t             grants_due [$];
    int                 errors;

    function void note_interval(interval_t it);
      bit [PRIO_W-1:0] prio;
      grant_t          g;
      int              pick;
      int              victim;
      g      = '{default: 0};
      pick   = -1;
      victim = -1;
      // a new function drops every holder; stale slot contents are never read
      if (it.newf) begin
        foreach (busy[s]) busy[s] = 1'b0;
        stamp       = '0;
        spills      = '0;
        callee_mask = '0;
      end
      prio = PRIO_W'(it.wcount) * 8 + PRIO_W'(it.acount) * 2 +
             PRIO_W'(it.bcount) * 16 + PRIO_W'(it.is_param) * 8;
      // expiry: holders whose end lies before the new start
      for (int s = 0; s < NSLOT; s++)
        if (busy[s] && hold_end[s] < it.start_pos) busy[s] = 1'b0;
      // x8 first for values not live across a call, then lowest free callee-saved
      if (!it.crosses_call && !busy[0]) pick = 0;
      for (int s = 1; pick < 0 && s < NSLOT; s++)
        if (!busy[s]) pick = s;
      if (pick < 0) begin
        // weakest legal holder: lowest priority, then later end, then older stamp
        for (int s = it.crosses_call ? 1 : 0; s < NSLOT; s++) begin
          if (!busy[s]) continue;
          if (victim < 0 || hold_prio[s] < hold_prio[victim] ||
              (hold_prio[s] == hold_prio[victim] &&
               (hold_end[s] > hold_end[victim] ||
                (hold_end[s] == hold_end[victim] &&
                 hold_stamp[s] < hold_stamp[victim]))))
            victim = s;
        end
        if (victim >= 0 && hold_prio[victim] < prio) begin
          pick           = victim;
          g.evicted      = 1'b1;
          g.evicted_temp = hold_id[victim];
          if (spills != '1) spills++;
        end
      end
      if (pick < 0) begin
        if (spills != '1) spills++;
      end else begin
        busy[pick]       = 1'b1;
        hold_end[pick]   = it.end_pos;
        hold_prio[pick]  = prio;
        hold_id[pick]    = it.temp_id;
        hold_stamp[pick] = stamp;
        stamp++;
        g.granted = 1'b1;
        if (pick == 0) begin
          g.reg_num = REG_NUM_W'(CALLER_REG);
        end else begin
          g.reg_num   = REG_NUM_W'(FIRST_CALLEE + pick - 1);
          callee_mask = callee_mask | (MASK_W'(1) << (pick - 1));
        end
      end
      g.spill_total = spills;
      g.used_mask   = callee_mask;
      grants_due = {grants_due, g};
    endfunction

    function void match_field(string what, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      if (grants_due.size() == 0) begin
        $display("%0t mismatch unexpected result: expected none actual reg %0d spills %0d",
                 $time, got.reg_num, got.spill_total);
        errors++;
        return;
      end
      want = grants_due.pop_front();
      match_field("granted", want.granted, got.granted);
      match_field("reg_num", want.reg_num, got.reg_num);
      match_field("evicted", want.evicted, got.evicted);
      match_field("evicted_temp", want.evicted_temp, got.evicted_temp);
      match_field("spill_total", want.spill_total, got.spill_total);
      match_field("callee_used_mask", want.used_mask, got.used_mask);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // new_function, temp_id, start_pos, end_pos, weighted_count, access_count,
  // block_count, is_param, crosses_call, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // granted, reg_num, evicted, evicted_temp, spill_total, callee_used_mask,
  // zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  regalloc_book book = new();
  bit           calm;
  int           sent;
  int           idle_cycles;

  linear_scan_register_assign_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic interval_t mk(bit newf, int unsigned id, int unsigned sp,
                                   int unsigned ep, int unsigned wc, int unsigned ac,
                                   int unsigned bc, bit prm, bit cc);
    interval_t it;
    it.newf         = newf;
    it.temp_id      = TEMP_ID_W'(id);
    it.start_pos    = POS_W'(sp);
    it.end_pos      = POS_W'(ep);
    it.wcount       = WCOUNT_W'(wc);
    it.acount       = ACOUNT_W'(ac);
    it.bcount       = BCOUNT_W'(bc);
    it.is_param     = prm;
    it.crosses_call = cc;
    return it;
  endfunction

  // presents one interval from a falling edge and returns at the falling edge
  // after its transaction; valid stays high between back-to-back items
  task automatic push_interval(interval_t it);
    logic [IN_TDATA_W-1:0] beat;
    int                    gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    beat = '0;
    beat[IN_NEWF_LSB]                 = it.newf;
    beat[IN_ID_LSB    +: TEMP_ID_W]   = it.temp_id;
    beat[IN_START_LSB +: POS_W]       = it.start_pos;
    beat[IN_END_LSB   +: POS_W]       = it.end_pos;
    beat[IN_WCNT_LSB  +: WCOUNT_W]    = it.wcount;
    beat[IN_ACNT_LSB  +: ACOUNT_W]    = it.acount;
    beat[IN_BCNT_LSB  +: BCOUNT_W]    = it.bcount;
    beat[IN_PARAM_LSB]                = it.is_param;
    beat[IN_CROSS_LSB]                = it.crosses_call;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_interval(it);
    sent++;
    @(negedge clk_i);
  endtask

  // one function's worth of intervals with rising starts and random content
  task automatic run_function();
    int unsigned len;
    int unsigned mode;
    int unsigned pos;
    int unsigned sp;
    int unsigned ep;
    int unsigned wc;
    int unsigned ac;
    int unsigned bc;
    len  = $urandom_range(8, 60);
    mode = $urandom_range(0, 2);
    pos  = $urandom_range(16, 20'hFFFFF - 8192);
    for (int k = 0; k < len; k++) begin
      pos += $urandom_range(0, 3);
      sp = pos;
      // now and then a start that steps backwards
      if (k > 0 && $urandom_range(0, 19) == 0) sp = pos - $urandom_range(0, 16);
      case ($urandom_range(0, 9))
        0:       ep = sp + $urandom_range(0, 8191);
        1:       ep = sp - $urandom_range(1, 8);
        default: ep = sp + $urandom_range(0, 64);
      endcase
      // tiny priorities give plenty of ties on priority and end
      case (mode)
        0: begin
          wc = $urandom_range(0, 2);
          ac = $urandom_range(0, 2);
          bc = $urandom_range(0, 1);
        end
        1: begin
          wc = $urandom_range(0, 1000);
          ac = $urandom_range(0, 255);
          bc = $urandom_range(0, 15);
        end
        default: begin
          wc = $urandom;
          ac = $urandom;
          bc = $urandom;
        end
      endcase
      push_interval(mk(k == 0, $urandom, sp, ep, wc, ac, bc, $urandom_range(0, 1),
                       $urandom_range(0, 2) == 0));
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    calm          = 1'b0;
    sent          = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fresh function: x8 for a call-free value, then the strongest possible
    // interval takes x19
    push_interval(mk(1, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
    push_interval(mk(0, 16'hFFFF, 0, 20'hFFFFF, 32'hFFFFFFFF, 16'hFFFF, 12'hFFF, 1, 1));
    // x8 expires at start 1; call-crossing values fill x20..x28 with equal
    // priority, two groups of equal ends
    for (int i = 0; i < 9; i++)
      push_interval(mk(0, 100 + i, 1, (i < 4) ? 1000 : 2000, 1, 0, 0, 0, 1));
    // x8 free again, then evictions decided by later end and older insertion
    push_interval(mk(0, 200, 2, 3000, 1, 1, 0, 0, 0));
    push_interval(mk(0, 201, 2, 3000, 1, 1, 0, 0, 0));
    // equal priority is not enough to evict, zero priority always spills
    push_interval(mk(0, 202, 2, 3000, 1, 0, 0, 0, 1));
    push_interval(mk(0, 203, 2, 5, 0, 0, 0, 0, 0));
    // call-crossing newcomer may not take x8 from its holder
    push_interval(mk(0, 204, 2, 4000, 125, 0, 0, 0, 1));
    // end before start, then an interval starting past that end releases it
    push_interval(mk(0, 300, 10, 4, 100, 0, 0, 0, 0));
    push_interval(mk(0, 301, 5, 9, 200, 3, 2, 1, 0));
    // start going backwards
    push_interval(mk(0, 302, 3, 10, 2, 0, 0, 1, 0));
    // new function at the top of the position range
    push_interval(mk(1, 16'hAAAA, 20'hFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                     12'hFFF, 1, 0));
    push_interval(mk(0, 16'h5555, 20'hFFFFF, 20'hFFFFF, 0, 0, 0, 0, 1));
    push_interval(mk(1, 16'h1234, 0, 20'hFFFFF, 32'h80000000, 16'h8000, 12'h800, 0, 1));

    // mostly well-formed functions, some noise transactions in between
    while (sent < ITEM_TARGET) begin
      calm = (sent >= CALM_FROM);
      if ($urandom_range(0, 9) == 0)
        push_interval(mk($urandom_range(0, 7) == 0, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom_range(0, 1),
                         $urandom_range(0, 1)));
      else
        run_function();
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give the block time to show any stray result
    while (book.grants_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (book.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // result sink with stall bursts, steady once the run is calm
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // every result transaction is unpacked and checked against the oldest outcome
  always @(posedge clk_i) begin : result_monitor
    grant_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.granted      = m_axis_tdata[OUT_GRANT_LSB];
      got.reg_num      = m_axis_tdata[OUT_REG_LSB +: REG_NUM_W];
      got.evicted      = m_axis_tdata[OUT_EV_LSB];
      got.evicted_temp = m_axis_tdata[OUT_EVID_LSB +: TEMP_ID_W];
      got.spill_total  = m_axis_tdata[OUT_SPILL_LSB +: SPILL_W];
      got.used_mask    = m_axis_tdata[OUT_MASK_LSB +: MASK_W];
      book.check_grant(got);
    end
  end

  // watchdog: a long spell with no transaction on either side is a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
